### rtl/tmcr_pkg.sv
// Shared types, constants and helpers of the text-mode character raster.
package tmcr_pkg;

	// Screen geometry defaults
	localparam int COLS_DEF   = 32;
	localparam int ROWS_DEF   = 28;
	localparam int GLYPHS_DEF = 128;

	// Field widths
	localparam int REQ_W    = 2;
	localparam int ADDR_W   = 10;
	localparam int DATA_W   = 8;
	localparam int TEXT_W   = 7;
	localparam int PIX_W    = 8;
	localparam int COLUMN_W = 5;
	localparam int SCAN_W   = 8;

	// Memory geometry
	localparam int MEM_DEPTH = 1 << ADDR_W;
	localparam int LINE_W    = 3;
	localparam logic [LINE_W-1:0] LINE_LAST = '1;

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_TEXT_WR  = 2'd0,
		REQ_GLYPH_WR = 2'd1,
		REQ_SCAN     = 2'd2,
		REQ_NONE     = 2'd3
	} req_type_t;

	// Character code reduced modulo the glyph count (code below 128, count 16 or more)
	function automatic logic [7:0] glyph_code(input logic [TEXT_W-1:0] code, input int glyphs);
		logic [8:0] v;
		logic [8:0] g;
		v = {2'b00, code};
		g = 9'(glyphs);
		for (int i = 0; i < 8; i++) begin
			if (v >= g) begin
				v = v - g;
			end
		end
		return v[7:0];
	endfunction

endpackage

### rtl/tmcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/text_mode_character_raster.sv
// Top level of the text-mode character raster generator.
//
// One input channel (in_valid/in_ready) carries write and scan requests: a
// text RAM write stores the low 7 bits of wdata at addr, a glyph store write
// stores wdata at addr, a scan request yields the next 8-pixel slice in
// raster order. Writes give no result; request code 3 is dropped.
// One output channel (out_valid/out_ready) carries pixels, column, scanline
// and frame_end for each scan.
// A scan result passes through two registers: the text RAM read data at its
// transfer, then the glyph store read data, which is the output register.
// Throughput: one request per cycle while out_ready is high and the clearing
// pass is over; the two RAM read stages overlap.
// When the receiver stalls, the result holds in the output register and one
// more scan waits in the text-read stage; in_ready then drops.
// Reset: the raster position returns to the top left and the text RAM is
// cleared by a pass over all 1024 cells, one cell a cycle, with in_ready low.
// The glyph store is not cleared and must be loaded before display.
module text_mode_character_raster #(
	parameter int COLS   = tmcr_pkg::COLS_DEF,
	parameter int ROWS   = tmcr_pkg::ROWS_DEF,
	parameter int GLYPHS = tmcr_pkg::GLYPHS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tmcr_pkg::REQ_W-1:0]    req_type,
	input  logic [tmcr_pkg::ADDR_W-1:0]   addr,
	input  logic [tmcr_pkg::DATA_W-1:0]   wdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tmcr_pkg::PIX_W-1:0]    pixels,
	output logic [tmcr_pkg::COLUMN_W-1:0] column,
	output logic [tmcr_pkg::SCAN_W-1:0]   scanline,
	output logic                          frame_end
);

	import tmcr_pkg::*;

	localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int GCODE_W = $clog2(GLYPHS);
	localparam int CELL_RAW = ROW_W + COL_W + 1;
	localparam int CELL_W  = (CELL_RAW > ADDR_W) ? CELL_RAW : ADDR_W;
	localparam int GA_RAW  = GCODE_W + LINE_W;
	localparam int GA_W    = (GA_RAW > ADDR_W) ? GA_RAW : ADDR_W;
	localparam int CO_W    = (COL_W > COLUMN_W) ? COL_W : COLUMN_W;
	localparam int SL_RAW  = ROW_W + LINE_W;
	localparam int SL_W    = (SL_RAW > SCAN_W) ? SL_RAW : SCAN_W;

	// Raster position
	logic [COL_W-1:0]  col_q;
	logic [LINE_W-1:0] line_q;
	logic [ROW_W-1:0]  row_q;

	// Text RAM clearing pass
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	// Text-read stage
	logic                s1_valid_q;
	logic [LINE_W-1:0]   line_s1;
	logic [COLUMN_W-1:0] column_s1;
	logic [SCAN_W-1:0]   scanline_s1;
	logic                fend_s1;

	// Output register
	logic                out_valid_q;
	logic [COLUMN_W-1:0] column_q;
	logic [SCAN_W-1:0]   scanline_q;
	logic                fend_q;

	logic s2_free, s1_adv, accept, scan_acc;
	logic last_col, last_line, last_row;
	logic [CELL_W-1:0]   cell_ext;
	logic [CO_W-1:0]     col_ext;
	logic [SL_W-1:0]     sl_ext;
	logic [TEXT_W-1:0]   text_rd;
	logic [7:0]          code8;
	logic [GA_W-1:0]     gaddr_ext;
	logic                txt_we;
	logic [ADDR_W-1:0]   txt_waddr;
	logic [TEXT_W-1:0]   txt_wdata;

	// Handshake and stage control
	assign s2_free  = !out_valid_q || out_ready;
	assign s1_adv   = s1_valid_q && s2_free;
	assign in_ready = !clr_busy_q && (!s1_valid_q || s2_free);
	assign accept   = in_valid && in_ready;
	assign scan_acc = accept && (req_type_t'(req_type) == REQ_SCAN);

	// Position decode
	assign last_col  = (col_q == COL_W'(COLS - 1));
	assign last_line = (line_q == LINE_LAST);
	assign last_row  = (row_q == ROW_W'(ROWS - 1));
	assign cell_ext  = CELL_W'(row_q) * CELL_W'(COLS) + CELL_W'(col_q);
	assign col_ext   = CO_W'(col_q);
	assign sl_ext    = SL_W'({row_q, line_q});

	// Clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == ADDR_W'(MEM_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Raster counters step on each scan transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
			row_q  <= '0;
		end else if (scan_acc) begin
			if (!last_col) begin
				col_q <= col_q + 1'b1;
			end else begin
				col_q <= '0;
				if (!last_line) begin
					line_q <= line_q + 1'b1;
				end else begin
					line_q <= '0;
					row_q  <= last_row ? '0 : row_q + 1'b1;
				end
			end
		end
	end

	// Text RAM: clearing pass or write request
	assign txt_we    = clr_busy_q || (accept && (req_type_t'(req_type) == REQ_TEXT_WR));
	assign txt_waddr = clr_busy_q ? clr_cnt_q : addr;
	assign txt_wdata = clr_busy_q ? '0 : wdata[TEXT_W-1:0];

	tmcr_ram #(
		.WIDTH(TEXT_W),
		.DEPTH(MEM_DEPTH)
	) u_text_ram (
		.clk  (clk),
		.we   (txt_we),
		.waddr(txt_waddr),
		.wdata(txt_wdata),
		.re   (scan_acc),
		.raddr(cell_ext[ADDR_W-1:0]),
		.rdata(text_rd)
	);

	// Text-read stage control and slice position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (scan_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_acc) begin
			line_s1     <= line_q;
			column_s1   <= col_ext[COLUMN_W-1:0];
			scanline_s1 <= sl_ext[SCAN_W-1:0];
			fend_s1     <= last_col && last_line && last_row;
		end
	end

	// Glyph address from the character code
	assign code8     = glyph_code(text_rd, GLYPHS);
	assign gaddr_ext = GA_W'({code8[GCODE_W-1:0], line_s1});

	// Glyph store: read data is the output pixel register
	tmcr_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MEM_DEPTH)
	) u_glyph_ram (
		.clk  (clk),
		.we   (accept && (req_type_t'(req_type) == REQ_GLYPH_WR)),
		.waddr(addr),
		.wdata(wdata),
		.re   (s1_adv),
		.raddr(gaddr_ext[ADDR_W-1:0]),
		.rdata(pixels)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_free) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			column_q   <= column_s1;
			scanline_q <= scanline_s1;
			fend_q     <= fend_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign column    = column_q;
	assign scanline  = scanline_q;
	assign frame_end = fend_q;

endmodule

### rtl/tmcr_chk.sv
// Port-level checker for the text-mode character raster, bound to the top level.
module tmcr_chk #(
	parameter int COLS = tmcr_pkg::COLS_DEF,
	parameter int ROWS = tmcr_pkg::ROWS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [tmcr_pkg::PIX_W-1:0]    pixels,
	input logic [tmcr_pkg::COLUMN_W-1:0] column,
	input logic [tmcr_pkg::SCAN_W-1:0]   scanline,
	input logic                          frame_end
);

	import tmcr_pkg::*;

	localparam logic [COLUMN_W-1:0] COL_LAST  = COLUMN_W'(COLS - 1);
	localparam logic [SCAN_W-1:0]   SCAN_LAST = SCAN_W'(ROWS * 8 - 1);

	logic                out_xfer;
	logic                seen_q;
	logic                fend_prev_q;
	logic [COLUMN_W-1:0] col_prev_q;
	logic [COLUMN_W-1:0] col_expect;

	assign out_xfer   = out_valid && out_ready;
	assign col_expect = (col_prev_q == COL_LAST) ? '0 : col_prev_q + 1'b1;

	// Track the previous result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			fend_prev_q <= 1'b0;
			col_prev_q  <= '0;
		end else if (out_xfer) begin
			seen_q      <= 1'b1;
			fend_prev_q <= frame_end;
			col_prev_q  <= column;
		end
	end

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixels) && $stable(column)
			&& $stable(scanline) && $stable(frame_end))
		else $error("result changed while stalled");

	// End of frame sits at the last column of the last screen line
	a_fend_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> column == COL_LAST && scanline == SCAN_LAST)
		else $error("frame end at wrong position");

	// Columns advance by one and wrap
	a_col_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q |-> column == col_expect)
		else $error("column out of sequence");

	// A new frame starts at the top left
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q && fend_prev_q |-> column == '0 && scanline == '0)
		else $error("frame did not restart at top left");

endmodule

bind text_mode_character_raster tmcr_chk #(
	.COLS(COLS),
	.ROWS(ROWS)
) u_tmcr_chk (.*);

### bench/text_mode_character_raster_check.sv
// Checker for the text-mode character raster: predicts every slice and compares the output.
module text_mode_character_raster_check
	import tmcr_pkg::*;
#(
	parameter int COLS   = COLS_DEF,
	parameter int ROWS   = ROWS_DEF,
	parameter int GLYPHS = GLYPHS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [ADDR_W-1:0]   addr,
	input  logic [DATA_W-1:0]   wdata,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [PIX_W-1:0]    pixels,
	input  logic [COLUMN_W-1:0] column,
	input  logic [SCAN_W-1:0]   scanline,
	input  logic                frame_end,
	output int                  bad_slices,
	output int                  slices_due
);

	localparam int LINES = 1 << LINE_W;

	typedef struct packed {
		logic [PIX_W-1:0]    pixels;
		logic [COLUMN_W-1:0] column;
		logic [SCAN_W-1:0]   scanline;
		logic                frame_end;
	} slice_t;

	// Shadow copies of both memories and the raster position
	logic [TEXT_W-1:0] text_cells [MEM_DEPTH];
	logic [PIX_W-1:0]  glyph_rows [MEM_DEPTH];
	int unsigned       col_pos;
	int unsigned       line_pos;
	int unsigned       row_pos;
	int                fails;
	slice_t            slice_q [$];

	always @(posedge clk or negedge arst_n) begin
		slice_t            want;
		slice_t            got;
		int unsigned       cell_idx;
		int unsigned       code;
		logic [ADDR_W-1:0] gaddr;
		if (!arst_n) begin
			for (int i = 0; i < MEM_DEPTH; i++) begin
				text_cells[i] = '0;
				glyph_rows[i] = '0;
			end
			col_pos  = 0;
			line_pos = 0;
			row_pos  = 0;
			fails    = 0;
			slice_q.delete();
			bad_slices <= 0;
			slices_due <= 0;
		end else begin
			// Output transfer: compare with the oldest predicted slice
			if (out_valid && out_ready) begin
				got = '{pixels, column, scanline, frame_end};
				if (slice_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected slice: pix %02h col %0d line %0d end %0b",
							got.pixels, got.column, got.scanline, got.frame_end);
				end else begin
					want = slice_q.pop_front();
					if (got.pixels !== want.pixels || got.column !== want.column ||
						got.scanline !== want.scanline || got.frame_end !== want.frame_end) begin
						fails++;
						if (fails <= 10) begin
							$write("slice mismatch: want pix %02h col %0d line %0d end %0b, ",
								want.pixels, want.column, want.scanline, want.frame_end);
							$display("got pix %02h col %0d line %0d end %0b",
								got.pixels, got.column, got.scanline, got.frame_end);
						end
					end
				end
			end

			// Input transfer: update memories or step the raster
			if (in_valid && in_ready) begin
				case (req_type_t'(req_type))
					REQ_TEXT_WR: begin
						text_cells[addr] = wdata[TEXT_W-1:0];
					end
					REQ_GLYPH_WR: begin
						glyph_rows[addr] = wdata;
					end
					REQ_SCAN: begin
						cell_idx = (row_pos * COLS + col_pos) % MEM_DEPTH;
						code     = int'(text_cells[cell_idx]) % GLYPHS;
						gaddr    = ADDR_W'(code * LINES + line_pos);
						want.pixels    = glyph_rows[gaddr];
						want.column    = COLUMN_W'(col_pos);
						want.scanline  = SCAN_W'(row_pos * LINES + line_pos);
						want.frame_end = (col_pos + 1 >= COLS) && (line_pos + 1 >= LINES) &&
							(row_pos + 1 >= ROWS);
						slice_q.push_back(want);
						// column, then glyph line, then character row
						if (col_pos + 1 < COLS) begin
							col_pos++;
						end else begin
							col_pos = 0;
							if (line_pos + 1 < LINES) begin
								line_pos++;
							end else begin
								line_pos = 0;
								row_pos  = (row_pos + 1 < ROWS) ? row_pos + 1 : 0;
							end
						end
					end
					default: begin
					end
				endcase
			end

			bad_slices <= fails;
			slices_due <= slice_q.size();
		end
	end

endmodule

### bench/text_mode_character_raster_test.sv
// Testbench top of the text-mode character raster: reset, stimulus, handshake pacing and verdict.
module text_mode_character_raster_test;

	import tmcr_pkg::*;

	localparam int LINES     = 1 << LINE_W;
	localparam int CODES     = 1 << TEXT_W;
	localparam int VISIBLE   = ROWS_DEF * COLS_DEF;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [REQ_W-1:0]    req_type  = REQ_NONE;
	logic [ADDR_W-1:0]   addr      = '0;
	logic [DATA_W-1:0]   wdata     = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [PIX_W-1:0]    pixels;
	logic [COLUMN_W-1:0] column;
	logic [SCAN_W-1:0]   scanline;
	logic                frame_end;
	int                  bad_slices;
	int                  slices_due;

	// Pacing: when set, neither side idles
	bit steady = 1'b0;
	int stall  = 0;

	// Which glyph bytes are loaded, and which codes are safe to display
	bit   glyph_set  [MEM_DEPTH];
	bit   code_ready [CODES];
	int   ready_codes [$];

	always #4 clk = ~clk;

	text_mode_character_raster #(
		.COLS   (COLS_DEF),
		.ROWS   (ROWS_DEF),
		.GLYPHS (GLYPHS_DEF)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.addr      (addr),
		.wdata     (wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixels    (pixels),
		.column    (column),
		.scanline  (scanline),
		.frame_end (frame_end)
	);

	text_mode_character_raster_check #(
		.COLS   (COLS_DEF),
		.ROWS   (ROWS_DEF),
		.GLYPHS (GLYPHS_DEF)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.addr       (addr),
		.wdata      (wdata),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixels     (pixels),
		.column     (column),
		.scanline   (scanline),
		.frame_end  (frame_end),
		.bad_slices (bad_slices),
		.slices_due (slices_due)
	);

	// Receiver: after each transfer, unless pacing is steady, hold ready low for a randomly drawn stall
	always @(posedge clk or negedge arst_n) begin
		int draw;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall     <= 0;
		end else if (stall > 0) begin
			stall     <= stall - 1;
			out_ready <= (stall == 1);
		end else if (out_valid && out_ready && !steady) begin
			draw = $urandom_range(0, 3);
			stall     <= draw;
			out_ready <= (draw == 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// One request transfer, preceded by a random gap
	task automatic send(input req_type_t kind, input logic [ADDR_W-1:0] a,
		input logic [DATA_W-1:0] d);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if ($urandom_range(0, 31) == 0)
			steady <= ($urandom_range(0, 2) == 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		addr     <= a;
		wdata    <= d;
		do @(posedge clk); while (!in_ready);
	endtask

	// Glyph byte write; a code becomes displayable once all its lines are loaded
	task automatic put_glyph(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		int  code;
		bit  full;
		send(REQ_GLYPH_WR, a, d);
		glyph_set[a] = 1'b1;
		code = a / LINES;
		full = 1'b1;
		for (int i = 0; i < LINES; i++)
			if (!glyph_set[code * LINES + i])
				full = 1'b0;
		if (full && !code_ready[code]) begin
			code_ready[code] = 1'b1;
			ready_codes.push_back(code);
		end
	endtask

	// Text write: visible cells only get loaded codes, hidden cells get anything
	task automatic put_text();
		logic [ADDR_W-1:0] a;
		logic [DATA_W-1:0] d;
		if ($urandom_range(0, 4) == 0) begin
			a = ADDR_W'($urandom_range(VISIBLE, MEM_DEPTH - 1));
			d = DATA_W'($urandom);
		end else begin
			a = ADDR_W'($urandom_range(0, VISIBLE - 1));
			d = {1'($urandom), TEXT_W'(ready_codes[$urandom_range(0, ready_codes.size() - 1)])};
		end
		send(REQ_TEXT_WR, a, d);
	endtask

	// Let every outstanding slice come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (slices_due != 0);
	endtask

	initial begin
		int sent;
		int pick;
		int code;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: dropped request, glyph 0 and last glyph, edge cells, scans
		send(REQ_NONE, '1, '1);
		put_glyph(10'd0, 8'h00);
		put_glyph(10'd1, 8'hff);
		put_glyph(10'd2, 8'h80);
		put_glyph(10'd3, 8'h01);
		put_glyph(10'd4, 8'haa);
		put_glyph(10'd5, 8'h55);
		put_glyph(10'd6, 8'h0f);
		put_glyph(10'd7, 8'hf0);
		for (int i = 0; i < LINES; i++)
			put_glyph(ADDR_W'(MEM_DEPTH - LINES + i), DATA_W'(8'h81 << i));
		send(REQ_TEXT_WR, 10'd0, 8'hff);
		send(REQ_TEXT_WR, 10'd1023, 8'h80);
		send(REQ_TEXT_WR, 10'd31, 8'h7f);
		send(REQ_SCAN, '0, '0);
		send(REQ_SCAN, '1, '1);
		send(REQ_SCAN, 10'h2aa, 8'h55);
		send(REQ_SCAN, 10'h155, 8'haa);
		drain();

		// Random mix: scans, text writes, whole glyph loads, stray glyph bytes, noise
		sent = 0;
		while (sent < 1200) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send(REQ_SCAN, ADDR_W'($urandom), DATA_W'($urandom));
				sent++;
			end else if (pick < 65) begin
				put_text();
				sent++;
			end else if (pick < 80) begin
				code = $urandom_range(0, CODES - 1);
				for (int i = 0; i < LINES; i++)
					put_glyph(ADDR_W'(code * LINES + i), DATA_W'($urandom));
				sent += LINES;
			end else if (pick < 92) begin
				put_glyph(ADDR_W'($urandom), DATA_W'($urandom));
				sent++;
			end else begin
				send(REQ_NONE, ADDR_W'($urandom), DATA_W'($urandom));
			end
		end
		drain();
		repeat (8) @(posedge clk);

		if (bad_slices == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog
	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
